>>> sv/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the descending record sorter.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int KEY_W           = 32;
    localparam int TAG_W           = 6;
    localparam int REC_W           = KEY_W + TAG_W;
    localparam int TDATA_W         = ((REC_W + 7) / 8) * 8;
    localparam int MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } rec_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_CHK,
        ST_PASS_RD0,
        ST_PASS_LD0,
        ST_RD,
        ST_CMP,
        ST_PEND,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic store;      // write the incoming record, count it or flag overflow
        logic close_set;  // incoming record ends the set: capture last index
        logic rd_first;   // read address zero instead of the position counter
        logic pos_one;
        logic pos_clear;
        logic pos_inc;
        logic hold_load;  // carried record takes the read data
        logic cmp_step;   // compare, write back the larger-or-equal side
        logic hold_store; // carried record goes to the pass end, pass end steps down
        logic out_load;
        logic set_clear;
    } cmd_t;

    typedef struct packed {
        logic end_zero;
        logic end_one;
        logic pos_at_end;
        logic out_last;
        logic out_done;
    } stat_t;

endpackage

>>> sv/drs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_ctrl
// Sequencer for load, bubble passes and emission of the record set.
// ----------------------------------------------------------------------------
module drs_ctrl
    import drs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  s_tlast,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.store = 1'b1;
                    if (s_tlast) begin
                        cmd.close_set = 1'b1;
                        state_next    = ST_SORT_CHK;
                    end
                end
            end
            ST_SORT_CHK: begin
                if (stat.end_zero) begin
                    cmd.pos_clear = 1'b1;
                    state_next    = ST_EMIT_RD;
                end else begin
                    state_next = ST_PASS_RD0;
                end
            end
            ST_PASS_RD0: begin
                cmd.rd_first = 1'b1;
                cmd.pos_one  = 1'b1;
                state_next   = ST_PASS_LD0;
            end
            ST_PASS_LD0: begin
                cmd.hold_load = 1'b1;
                state_next    = ST_RD;
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                if (stat.pos_at_end) begin
                    state_next = ST_PEND;
                end else begin
                    cmd.pos_inc = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_PEND: begin
                cmd.hold_store = 1'b1;
                if (stat.end_one) begin
                    cmd.pos_clear = 1'b1;
                    state_next    = ST_EMIT_RD;
                end else begin
                    state_next = ST_PASS_RD0;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (stat.out_done) begin
                    if (stat.out_last) begin
                        cmd.set_clear = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.pos_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> sv/drs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_datapath
// Record store, carried record, counters and output register.
// ----------------------------------------------------------------------------
module drs_datapath
    import drs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TDATA_W-1:0] s_tdata,
    output logic [TDATA_W-1:0] m_tdata,  // [31:0] sorted_key, [37:32] sorted_tag
    output logic               m_tuser,  // [0] overflowed
    output logic               m_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  cmd_t               cmd,
    output stat_t              stat
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] FULL     = CW'(MAX_RECORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_RECORDS - 1);

    rec_t mem [MAX_RECORDS];

    rec_t          rd_data_reg;
    rec_t          hold_reg;
    rec_t          hold_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [AW-1:0] end_reg;
    logic [AW-1:0] end_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    rec_t          out_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    rec_t          in_rec;
    logic          not_full;
    logic          greater;
    logic          we;
    logic [AW-1:0] wr_addr;
    rec_t          wr_data;
    logic [AW-1:0] rd_addr;
    logic          is_last;

    assign in_rec   = rec_t'(s_tdata[REC_W-1:0]);
    assign not_full = (fill_reg < FULL);
    assign greater  = ($signed(rd_data_reg.key) > $signed(hold_reg.key));
    assign rd_addr  = cmd.rd_first ? '0 : pos_reg;
    assign is_last  = ((CW'(pos_reg) + CW'(1)) == fill_reg);

    always_comb begin
        we      = 1'b0;
        wr_addr = pos_reg - AW'(1);
        wr_data = hold_reg;
        if (cmd.store) begin
            we      = not_full;
            wr_addr = fill_reg[AW-1:0];
            wr_data = in_rec;
        end else if (cmd.cmp_step) begin
            we      = 1'b1;
            wr_data = greater ? rd_data_reg : hold_reg;
        end else if (cmd.hold_store) begin
            we      = 1'b1;
            wr_addr = end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        if (cmd.store) begin
            if (not_full) begin
                fill_next = fill_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.close_set) begin
            end_next = not_full ? fill_reg[AW-1:0] : LAST_IDX;
        end
        if (cmd.hold_store) begin
            end_next = end_reg - AW'(1);
        end
        if (cmd.pos_one) begin
            pos_next = AW'(1);
        end else if (cmd.pos_clear) begin
            pos_next = '0;
        end else if (cmd.pos_inc) begin
            pos_next = pos_reg + AW'(1);
        end
        if (cmd.hold_load || (cmd.cmp_step && !greater)) begin
            hold_next = rd_data_reg;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.set_clear) begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg  <= end_next;
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        if (cmd.out_load) begin
            out_reg      <= rd_data_reg;
            out_last_reg <= is_last;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tdata  = TDATA_W'(out_reg);
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    assign stat.end_zero   = (end_reg == '0);
    assign stat.end_one    = (end_reg == AW'(1));
    assign stat.pos_at_end = (pos_reg == end_reg);
    assign stat.out_last   = out_last_reg;
    assign stat.out_done   = out_valid_reg && m_tready;

endmodule

>>> sv/descending_record_sorter.sv
`timescale 1ns / 1ps
// A set is sorted in bubble passes, each compare reading the store through its registered
// read port; then the results are emitted one at a time, each read, loaded and held until taken.
// One record set is handled at a time: input is refused from the final transfer until the
// last result of the set is taken.
// Reset: synchronous, active low; clears record count, overflow flag and output valid.
// ----------------------------------------------------------------------------
// descending_record_sorter
// Collects a record set, bubble sorts it by signed key largest first, emits it.
// ----------------------------------------------------------------------------
module descending_record_sorter
    import drs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // [31:0] sort_key, [37:32] record_tag
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // [31:0] sorted_key, [37:32] sorted_tag
    output logic               m_tuser,  // [0] overflowed
    output logic               m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    drs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drs_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> sv/drs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_checker
// Port-level checks of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module drs_checker
    import drs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_load_excludes_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_final_in_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after final transfer");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind descending_record_sorter drs_checker u_drs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for descending_record_sorter. Record sets are streamed
// in with random bursts and gaps while the result side stalls on its own
// pattern. A bubble-sort predictor, stable on equal keys, builds the ranked
// results of every set, and each result transfer is checked field by field
// against them.
// ----------------------------------------------------------------------------
module testbench;
    import drs_pkg::*;

    localparam int  CAPACITY    = MAX_RECORDS_DEF;
    localparam int  LONG_HOLD   = 600;
    localparam int  TAIL_CYCLES = 300;
    localparam int  RAND_ITEMS  = 95;
    localparam time RUN_LIMIT   = 64'd10_000_000;

    typedef enum int {
        PACE_FREE,
        PACE_BUSY,
        PACE_LIGHT
    } pace_t;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    fin;
        logic                    drain_first;
    } offer_t;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
        logic                    ovf;
    } ranked_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    offer_t  offers[$];
    ranked_t ranks_due[$];

    logic signed [KEY_W-1:0] held_key [CAPACITY];
    logic [TAG_W-1:0]        held_tag [CAPACITY];
    int                      held_count   = 0;
    logic                    held_dropped = 1'b0;

    logic s_fire = 1'b0;
    int   errors        = 0;
    int   records_taken = 0;
    int   results_seen  = 0;
    int   sets_closed   = 0;
    int   overflow_sets = 0;

    descending_record_sorter #(
        .MAX_RECORDS(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d results outstanding", ranks_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2) begin
            return $signed($urandom_range(0, 6)) - 3;
        end else if (sel == 2) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_record(input logic signed [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                                input logic fin, input logic drain_first);
        offer_t o;
        o.key = k;
        o.tag = t;
        o.fin = fin;
        o.drain_first = drain_first;
        offers.push_back(o);
    endtask

    task automatic queue_set(input int size, input logic drain_first);
        int i;
        for (i = 0; i < size; i++) begin
            queue_record(pick_key(), TAG_W'($urandom_range(0, 63)), i == size - 1,
                         drain_first && i == 0);
        end
    endtask

    // Predictor: store or drop the record, and on the closing record rank the set
    task automatic file_record(input logic signed [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                               input logic fin);
        int                      p;
        int                      q;
        logic signed [KEY_W-1:0] sk;
        logic [TAG_W-1:0]        st;
        ranked_t                 r;
        if (held_count < CAPACITY) begin
            held_key[held_count] = k;
            held_tag[held_count] = t;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (fin) begin
            for (p = 0; p < held_count; p++) begin
                for (q = 1; q + p < held_count; q++) begin
                    if (held_key[q] > held_key[q-1]) begin
                        sk = held_key[q-1];
                        st = held_tag[q-1];
                        held_key[q-1] = held_key[q];
                        held_tag[q-1] = held_tag[q];
                        held_key[q] = sk;
                        held_tag[q] = st;
                    end
                end
            end
            for (p = 0; p < held_count; p++) begin
                r.key  = held_key[p];
                r.tag  = held_tag[p];
                r.last = (p == held_count - 1);
                r.ovf  = held_dropped;
                ranks_due.push_back(r);
            end
            sets_closed++;
            if (held_dropped) overflow_sets++;
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // Sender: bursts of transfers separated by gaps
    always @(negedge aclk) begin : sender
        int     burst_left;
        int     gap_left;
        offer_t o;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (offers.size() != 0 &&
                         !(offers[0].drain_first && ranks_due.size() != 0)) begin
                o = offers.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(TDATA_W - KEY_W - TAG_W){1'b0}}, o.tag, o.key};
                s_tlast  <= o.fin;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall pattern, plus one long hold-off
    always @(negedge aclk) begin : receiver
        int    hold_off;
        int    pace_left;
        bit    long_hold_done;
        pace_t pace;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_off = 0;
            pace_left = 0;
            long_hold_done = 1'b0;
            pace = PACE_FREE;
        end else if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_off = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace = pace_t'($urandom_range(0, 2));
                pace_left = $urandom_range(8, 40);
            end else begin
                pace_left--;
            end
            case (pace)
                PACE_FREE:  m_tready <= 1'b1;
                PACE_BUSY:  m_tready <= 1'($urandom_range(0, 1));
                default:    m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: feed accepted records to the predictor, check result transfers
    always @(posedge aclk) begin : monitor
        ranked_t r;
        logic signed [KEY_W-1:0] got_key;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                records_taken++;
                file_record(s_tdata[KEY_W-1:0], s_tdata[KEY_W +: TAG_W], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_key = m_tdata[KEY_W-1:0];
                if (ranks_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: key %0d tag %0d last %0b ovf %0b",
                             $time, got_key, m_tdata[KEY_W +: TAG_W], m_tlast, m_tuser);
                end else begin
                    r = ranks_due.pop_front();
                    if (got_key !== r.key || m_tdata[KEY_W +: TAG_W] !== r.tag ||
                        m_tlast !== r.last || m_tuser !== r.ovf) begin
                        errors++;
                        $display("%0t: mismatch: expected key %0d tag %0d last %0b ovf %0b",
                                 $time, r.key, r.tag, r.last, r.ovf);
                        $display("%0t:           actual   key %0d tag %0d last %0b ovf %0b",
                                 $time, got_key, m_tdata[KEY_W +: TAG_W], m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int set_no;
        int rand_items;
        int size;

        // single-record sets at the key extremes
        queue_record(32'sh7FFF_FFFF, 6'd63, 1'b1, 1'b0);
        queue_record(32'sh8000_0000, 6'd0, 1'b1, 1'b0);
        // mixed extremes
        queue_record(-32'sd1, 6'd1, 1'b0, 1'b0);
        queue_record(32'sd0, 6'd2, 1'b0, 1'b0);
        queue_record(32'sh7FFF_FFFF, 6'd3, 1'b0, 1'b0);
        queue_record(32'sh8000_0000, 6'd4, 1'b1, 1'b0);
        // equal keys must keep arrival order
        queue_record(32'sd5, 6'd10, 1'b0, 1'b0);
        queue_record(-32'sd7, 6'd11, 1'b0, 1'b0);
        queue_record(32'sd5, 6'd12, 1'b0, 1'b0);
        queue_record(32'sd5, 6'd13, 1'b0, 1'b0);
        queue_record(-32'sd7, 6'd14, 1'b1, 1'b0);
        // already descending, then ascending
        queue_record(32'sd3, 6'd20, 1'b0, 1'b0);
        queue_record(32'sd2, 6'd21, 1'b0, 1'b0);
        queue_record(32'sd1, 6'd22, 1'b1, 1'b0);
        queue_record(32'sd1, 6'd30, 1'b0, 1'b0);
        queue_record(32'sd2, 6'd31, 1'b0, 1'b0);
        queue_record(32'sd3, 6'd32, 1'b0, 1'b0);
        queue_record(32'sd4, 6'd33, 1'b1, 1'b0);
        // signed compare across zero
        queue_record(-32'sd1, 6'd40, 1'b0, 1'b0);
        queue_record(32'sd1, 6'd41, 1'b1, 1'b0);

        // random sets; one exactly full
        set_no = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            if (set_no == 3) begin
                size = CAPACITY;
            end else if ($urandom_range(0, 7) == 0) begin
                size = $urandom_range(7, 20);
            end else begin
                size = $urandom_range(1, 6);
            end
            queue_set(size, set_no == 0 || set_no == 5);
            rand_items += size;
            set_no++;
        end
        // final dropped by itself: store fills on the record before it
        queue_set(CAPACITY + 1, 1'b1);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (offers.size() != 0 || s_tvalid || ranks_due.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d record transfers in %0d sets (%0d with dropped records)",
                 records_taken, sets_closed, overflow_sets);
        $display("checked %0d ranked results", results_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
